### design/d4w_pkg.sv
// ----------------------------------------------------------------------------
// d4w_pkg
// Shared constants, filter tap table and selector codes for the D4 wavelet.
// ----------------------------------------------------------------------------
package d4w_pkg;

   localparam int MAX_LEN_DEF    = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int TAP_WIDTH      = 17;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;

   localparam logic [2:0] LEN_LOG2_RESET = 3'd6;

   localparam logic CSR_IDX_DIRECTION = 1'b0;
   localparam logic CSR_IDX_LENGTH    = 1'b1;

   localparam logic [1:0] TSEL_FWD_LO   = 2'd0;
   localparam logic [1:0] TSEL_FWD_HI   = 2'd1;
   localparam logic [1:0] TSEL_INV_EVEN = 2'd2;
   localparam logic [1:0] TSEL_INV_ODD  = 2'd3;

   localparam logic signed [TAP_WIDTH-1:0] TAP_TABLE [16] = '{
      17'sd31651,  17'sd54822,  17'sd14689, -17'sd8481,
      -17'sd8481, -17'sd14689,  17'sd54822, -17'sd31651,
      17'sd14689,  17'sd54822,  17'sd31651, -17'sd8481,
      -17'sd8481, -17'sd31651,  17'sd54822, -17'sd14689
   };

   function automatic logic signed [TAP_WIDTH-1:0] tap_coef(input logic [1:0] sel,
                                                           input logic [1:0] k);
      return TAP_TABLE[{sel, k}];
   endfunction

endpackage

### design/d4w_ram.sv
// ----------------------------------------------------------------------------
// d4w_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module d4w_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/d4w_datapath.sv
// ----------------------------------------------------------------------------
// d4w_datapath
// Sample and work stores, tap multiply-accumulate pipeline, output register.
// ----------------------------------------------------------------------------
module d4w_datapath #(
   parameter int MAX_LEN    = d4w_pkg::MAX_LEN_DEF,
   parameter int DATA_WIDTH = d4w_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DATA_WIDTH-1:0] req_sample,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_coefficient,
   output logic                  rsp_last_out,
   input  logic [$clog2(MAX_LEN)*5+9-1:0] cmd_bits,
   output logic [1:0]            status_bits
);

   localparam int AW  = $clog2(MAX_LEN);
   localparam int DW  = DATA_WIDTH;
   localparam int TW  = d4w_pkg::TAP_WIDTH;
   localparam int PW  = DW + TW;
   localparam int ACW = PW + 2;
   localparam logic signed [ACW-1:0] HALF = ACW'(1) <<< (d4w_pkg::FRAC_BITS - 1);

   typedef struct packed {
      logic          load_we;
      logic [AW-1:0] load_addr;
      logic          mac_rd;
      logic [AW-1:0] mac_addr;
      logic [1:0]    tap_sel;
      logic [1:0]    tap_k;
      logic [AW-1:0] dst_addr;
      logic          copy_rd;
      logic [AW-1:0] copy_addr;
      logic          emit_rd;
      logic [AW-1:0] emit_addr;
      logic          emit_last;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic out_busy;
   } status_type;

   cmd_type    cmd;
   status_type status;

   assign cmd         = cmd_bits;
   assign status_bits = status;

   logic          s_we;
   logic [AW-1:0] s_waddr;
   logic [DW-1:0] s_wdata;
   logic          s_re;
   logic [AW-1:0] s_raddr;
   logic [DW-1:0] s_rdata;
   logic          w_we;
   logic [DW-1:0] w_wdata;
   logic [DW-1:0] w_rdata;

   logic          m1_v_ff, m2_v_ff, m3_v_ff;
   logic [1:0]    m1_sel_ff, m1_k_ff, m2_k_ff;
   logic [AW-1:0] m1_dst_ff, m2_dst_ff, m3_dst_ff;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [ACW-1:0] acc_ff, acc_in, rnd_sum, shifted;
   logic          cp_v_ff;
   logic [AW-1:0] cp_addr_ff;
   logic          em_v_ff, em_last_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_data_ff;
   logic          rsp_last_ff;
   logic          fits;

   assign s_we    = cmd.load_we | cp_v_ff;
   assign s_waddr = cmd.load_we ? cmd.load_addr : cp_addr_ff;
   assign s_wdata = cmd.load_we ? req_sample : w_rdata;
   assign s_re    = cmd.mac_rd | cmd.emit_rd;
   assign s_raddr = cmd.mac_rd ? cmd.mac_addr : cmd.emit_addr;

   d4w_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_sample_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .re    (s_re),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   d4w_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_work_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (m3_dst_ff),
      .wdata (w_wdata),
      .re    (cmd.copy_rd),
      .raddr (cmd.copy_addr),
      .rdata (w_rdata)
   );

   always_comb begin
      prod_in = $signed(s_rdata) * d4w_pkg::tap_coef(m1_sel_ff, m1_k_ff);
      if (m2_k_ff == 2'd0) begin
         acc_in = {{2{prod_ff[PW-1]}}, prod_ff};
      end else begin
         acc_in = acc_ff + {{2{prod_ff[PW-1]}}, prod_ff};
      end
      rnd_sum = acc_ff + HALF;
      shifted = rnd_sum >>> d4w_pkg::FRAC_BITS;
      fits    = (&shifted[ACW-1:DW-1]) | ~(|shifted[ACW-1:DW-1]);
      if (fits) begin
         w_wdata = shifted[DW-1:0];
      end else if (shifted[ACW-1]) begin
         w_wdata = {1'b1, {(DW-1){1'b0}}};
      end else begin
         w_wdata = {1'b0, {(DW-1){1'b1}}};
      end
   end

   assign w_we = m3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
         cp_v_ff <= 1'b0;
         em_v_ff <= 1'b0;
      end else begin
         m1_v_ff <= cmd.mac_rd;
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff && (m2_k_ff == 2'd3);
         cp_v_ff <= cmd.copy_rd;
         em_v_ff <= cmd.emit_rd;
      end
      m1_sel_ff  <= cmd.tap_sel;
      m1_k_ff    <= cmd.tap_k;
      m1_dst_ff  <= cmd.dst_addr;
      prod_ff    <= prod_in;
      m2_k_ff    <= m1_k_ff;
      m2_dst_ff  <= m1_dst_ff;
      if (m2_v_ff) begin
         acc_ff <= acc_in;
      end
      m3_dst_ff  <= m2_dst_ff;
      cp_addr_ff <= cmd.copy_addr;
      em_last_ff <= cmd.emit_last;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (em_v_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (em_v_ff) begin
         rsp_data_ff <= s_rdata;
         rsp_last_ff <= em_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_data_ff;
   assign rsp_last_out    = rsp_last_ff;

   assign status.busy     = m1_v_ff | m2_v_ff | m3_v_ff | cp_v_ff;
   assign status.out_busy = em_v_ff | (rsp_valid_ff & rsp_stall);

endmodule

### design/d4w_ctrl.sv
// ----------------------------------------------------------------------------
// d4w_ctrl
// Sequencer: load count, pass schedule, tap addressing, copy-back, emission.
// ----------------------------------------------------------------------------
module d4w_ctrl #(
   parameter int MAX_LEN = d4w_pkg::MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       cfg_direction,
   input  logic [2:0] cfg_length_log2,
   output logic [$clog2(MAX_LEN)*5+9-1:0] cmd_bits,
   input  logic [1:0] status_bits
);

   localparam int AW   = $clog2(MAX_LEN);
   localparam int CW   = AW + 1;
   localparam int MAXK = $clog2(MAX_LEN + 1) - 1;
   localparam int KW   = $clog2(MAXK + 1);

   localparam logic [2:0] ST_LOAD       = 3'd0;
   localparam logic [2:0] ST_PASS       = 3'd1;
   localparam logic [2:0] ST_PASS_DRAIN = 3'd2;
   localparam logic [2:0] ST_COPY       = 3'd3;
   localparam logic [2:0] ST_COPY_DRAIN = 3'd4;
   localparam logic [2:0] ST_EMIT       = 3'd5;

   typedef struct packed {
      logic          load_we;
      logic [AW-1:0] load_addr;
      logic          mac_rd;
      logic [AW-1:0] mac_addr;
      logic [1:0]    tap_sel;
      logic [1:0]    tap_k;
      logic [AW-1:0] dst_addr;
      logic          copy_rd;
      logic [AW-1:0] copy_addr;
      logic          emit_rd;
      logic [AW-1:0] emit_addr;
      logic          emit_last;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic out_busy;
   } status_type;

   cmd_type    cmd;
   status_type status;

   assign cmd_bits = cmd;
   assign status   = status_bits;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] lc_ff, lc_in, lc_inc;
   logic [KW-1:0] kn_ff, kn_in, kn_cfg, pk_ff, pk_in;
   logic          dir_ff, dir_in;
   logic [CW-1:0] o_ff, o_in;
   logic [1:0]    t_ff, t_in;
   logic [CW-1:0] n_cfg, n_cur, m, nh, fi, fa, ii, sp, ia;
   logic          hi, accept, last_pass;

   always_comb begin
      if (cfg_length_log2 < 3'd2) begin
         kn_cfg = KW'(2);
      end else if (int'(cfg_length_log2) > MAXK) begin
         kn_cfg = KW'(MAXK);
      end else begin
         kn_cfg = KW'(cfg_length_log2);
      end
      n_cfg  = CW'(1) << kn_cfg;
      n_cur  = CW'(1) << kn_ff;
      lc_inc = lc_ff + CW'(1);
      m      = CW'(1) << pk_ff;
      nh     = m >> 1;
      hi     = o_ff >= nh;
      fi     = hi ? (o_ff - nh) : o_ff;
      fa     = ((fi << 1) + CW'(t_ff)) & (m - CW'(1));
      ii     = o_ff >> 1;
      sp     = (ii + nh - CW'(1)) & (nh - CW'(1));
      unique case (t_ff)
         2'd0:    ia = sp;
         2'd1:    ia = sp + nh;
         2'd2:    ia = ii;
         default: ia = ii + nh;
      endcase
      last_pass = dir_ff ? (pk_ff == kn_ff) : (pk_ff == KW'(2));
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      lc_in    = lc_ff;
      kn_in    = kn_ff;
      dir_in   = dir_ff;
      pk_in    = pk_ff;
      o_in     = o_ff;
      t_in     = t_ff;
      cmd           = '0;
      cmd.load_we   = accept;
      cmd.load_addr = lc_ff[AW-1:0];
      cmd.mac_addr  = dir_ff ? ia[AW-1:0] : fa[AW-1:0];
      cmd.tap_sel   = dir_ff ? (o_ff[0] ? d4w_pkg::TSEL_INV_ODD : d4w_pkg::TSEL_INV_EVEN)
                             : (hi ? d4w_pkg::TSEL_FWD_HI : d4w_pkg::TSEL_FWD_LO);
      cmd.tap_k     = t_ff;
      cmd.dst_addr  = o_ff[AW-1:0];
      cmd.copy_addr = o_ff[AW-1:0];
      cmd.emit_addr = o_ff[AW-1:0];
      cmd.emit_last = (o_ff == n_cur - CW'(1));
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               lc_in = lc_inc;
               if (lc_inc >= n_cfg) begin
                  lc_in  = '0;
                  kn_in  = kn_cfg;
                  dir_in = cfg_direction;
                  o_in   = '0;
                  t_in   = '0;
                  pk_in  = cfg_direction ? KW'(2) : kn_cfg;
                  state_in = (kn_cfg > KW'(2)) ? ST_PASS : ST_EMIT;
               end
            end
         end
         ST_PASS: begin
            cmd.mac_rd = 1'b1;
            t_in = t_ff + 2'd1;
            if (t_ff == 2'd3) begin
               o_in = o_ff + CW'(1);
               if (o_ff == m - CW'(1)) begin
                  state_in = ST_PASS_DRAIN;
               end
            end
         end
         ST_PASS_DRAIN: begin
            if (!status.busy) begin
               o_in     = '0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            cmd.copy_rd = 1'b1;
            o_in = o_ff + CW'(1);
            if (o_ff == m - CW'(1)) begin
               state_in = ST_COPY_DRAIN;
            end
         end
         ST_COPY_DRAIN: begin
            if (!status.busy) begin
               o_in = '0;
               t_in = '0;
               if (last_pass) begin
                  state_in = ST_EMIT;
               end else begin
                  pk_in    = dir_ff ? (pk_ff + KW'(1)) : (pk_ff - KW'(1));
                  state_in = ST_PASS;
               end
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit_rd = 1'b1;
               o_in = o_ff + CW'(1);
               if (o_ff == n_cur - CW'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         lc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lc_ff    <= lc_in;
      end
      kn_ff  <= kn_in;
      dir_ff <= dir_in;
      pk_ff  <= pk_in;
      o_ff   <= o_in;
      t_ff   <= t_in;
   end

endmodule

### design/daubechies4_wavelet_multilevel.sv
// ----------------------------------------------------------------------------
// daubechies4_wavelet_multilevel
// Multilevel periodic Daubechies-4 wavelet transform, forward or inverse.
// ----------------------------------------------------------------------------
// Collects N = 2^length_log2 samples (one beat per cycle while loading),
// transforms them in place and returns N coefficients in index order, the last
// one flagged. Each pass over m points reads the sample store once per tap, four
// taps per output, on the single multiply-accumulate unit, then copies the pass
// back and lets the pipeline drain. An output beat is read only once the previous
// one is registered and not held by rsp_stall; loading of the next block starts
// as soon as the last read is issued. N = 4 skips the transform.
module daubechies4_wavelet_multilevel #(
   parameter int MAX_LEN    = d4w_pkg::MAX_LEN_DEF,
   parameter int DATA_WIDTH = d4w_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [DATA_WIDTH-1:0]        req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [DATA_WIDTH-1:0]        rsp_coefficient,
   output logic                         rsp_last_out,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [d4w_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [d4w_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [d4w_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int CMDW = $clog2(MAX_LEN)*5 + 9;

   logic            direction_ff;
   logic [2:0]      length_log2_ff;
   logic            csr_wr;
   logic [CMDW-1:0] cmd_bits;
   logic [1:0]      status_bits;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff   <= 1'b0;
         length_log2_ff <= d4w_pkg::LEN_LOG2_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == d4w_pkg::CSR_IDX_DIRECTION) begin
            direction_ff <= csr_pwdata[0];
         end else begin
            length_log2_ff <= csr_pwdata[2:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == d4w_pkg::CSR_IDX_LENGTH) begin
         csr_prdata = {{(d4w_pkg::CSR_DW-3){1'b0}}, length_log2_ff};
      end else begin
         csr_prdata = {{(d4w_pkg::CSR_DW-1){1'b0}}, direction_ff};
      end
   end

   d4w_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .cfg_direction   (direction_ff),
      .cfg_length_log2 (length_log2_ff),
      .cmd_bits        (cmd_bits),
      .status_bits     (status_bits)
   );

   d4w_datapath #(.MAX_LEN(MAX_LEN), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_coefficient (rsp_coefficient),
      .rsp_last_out    (rsp_last_out),
      .cmd_bits        (cmd_bits),
      .status_bits     (status_bits)
   );

endmodule

### design/d4w_checker.sv
// ----------------------------------------------------------------------------
// d4w_checker
// Port-level checks for the D4 wavelet block, bound to the top level.
// ----------------------------------------------------------------------------
module d4w_checker #(
   parameter int DATA_WIDTH = d4w_pkg::DATA_WIDTH_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [DATA_WIDTH-1:0]      req_sample,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [DATA_WIDTH-1:0]      rsp_coefficient,
   input logic                       rsp_last_out,
   input logic                       csr_psel,
   input logic                       csr_penable,
   input logic                       csr_pwrite,
   input logic [d4w_pkg::CSR_AW-1:0] csr_paddr,
   input logic [d4w_pkg::CSR_DW-1:0] csr_pwdata,
   input logic [d4w_pkg::CSR_DW-1:0] csr_prdata,
   input logic                       csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_coefficient)
                                 && $stable(rsp_last_out))
      else $error("stalled beat changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("beat after reset");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out && !rsp_stall |=> !rsp_valid)
      else $error("beat right after last beat");

   a_len_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr[2]) ##1
      (csr_psel && !csr_pwrite && csr_paddr[2])
      |-> csr_prdata[2:0] == $past(csr_pwdata[2:0]))
      else $error("length readback mismatch");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind daubechies4_wavelet_multilevel d4w_checker #(.DATA_WIDTH(DATA_WIDTH)) u_d4w_checker (.*);

### verif/daubechies4_wavelet_multilevel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// daubechies4_wavelet_multilevel_checker
// Watches the sample, coefficient and register ports of the D4 wavelet block,
// predicts every coefficient beat from the accepted samples and the register
// writes seen on the bus, and counts mismatches against the beats returned.
// ----------------------------------------------------------------------------
module daubechies4_wavelet_multilevel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_sample,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_coefficient,
   input  logic        rsp_last_out,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          coef_pending
);

   localparam longint H0 = 31651;
   localparam longint H1 = 54822;
   localparam longint H2 = 14689;
   localparam longint H3 = -8481;
   localparam longint DMAX = 64'sd2147483647;
   localparam longint DMIN = -64'sd2147483648;

   typedef struct {
      logic [31:0] coef;
      logic        last;
   } coef_beat_type;

   coef_beat_type coef_q[$];
   longint     signal_buf [64];
   longint     pass_buf [64];
   int         fill_count;
   logic       inverse_mode;
   logic [2:0] len_log2;

   function automatic longint tap_sum(longint a0, longint a1, longint a2, longint a3,
                                      longint x0, longint x1, longint x2, longint x3);
      longint acc;
      acc = a0 * x0 + a1 * x1 + a2 * x2 + a3 * x3 + 32768;
      acc = acc >>> 16;
      if (acc > DMAX) acc = DMAX;
      if (acc < DMIN) acc = DMIN;
      return acc;
   endfunction

   function automatic int block_points(logic [2:0] k);
      int e;
      e = k;
      if (e < 2) e = 2;
      if (e > 6) e = 6;
      return 1 << e;
   endfunction

   task automatic wavelet_pass(int m, logic inv);
      int     nh;
      int     j;
      int     sp;
      longint p0, p1, p2, p3;
      nh = m / 2;
      for (int i = 0; i < nh; i++) begin
         if (!inv) begin
            j  = 2 * i;
            p0 = signal_buf[j];
            p1 = signal_buf[j + 1];
            p2 = signal_buf[(j + 2) % m];
            p3 = signal_buf[(j + 3) % m];
            pass_buf[i]      = tap_sum(H0, H1, H2, H3, p0, p1, p2, p3);
            pass_buf[i + nh] = tap_sum(H3, -H2, H1, -H0, p0, p1, p2, p3);
         end else begin
            sp = (i + nh - 1) % nh;
            p0 = signal_buf[sp];
            p1 = signal_buf[sp + nh];
            p2 = signal_buf[i];
            p3 = signal_buf[i + nh];
            pass_buf[2 * i]     = tap_sum(H2, H1, H0, H3, p0, p1, p2, p3);
            pass_buf[2 * i + 1] = tap_sum(H3, -H0, H1, -H2, p0, p1, p2, p3);
         end
      end
      for (int i = 0; i < m; i++) signal_buf[i] = pass_buf[i];
   endtask

   task automatic take_sample(logic [31:0] s);
      int            n;
      coef_beat_type b;
      n = block_points(len_log2);
      if (fill_count < 64) signal_buf[fill_count] = longint'($signed(s));
      fill_count++;
      if (fill_count >= n) begin
         fill_count = 0;
         if (n > 4) begin
            if (!inverse_mode) begin
               for (int m = n; m >= 4; m = m / 2) wavelet_pass(m, 1'b0);
            end else begin
               for (int m = 4; m <= n; m = m * 2) wavelet_pass(m, 1'b1);
            end
         end
         for (int i = 0; i < n; i++) begin
            b.coef = signal_buf[i][31:0];
            b.last = (i == n - 1);
            coef_q.push_back(b);
         end
      end
   endtask

   task automatic check_beat(logic [31:0] c, logic l);
      coef_beat_type b;
      if (coef_q.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("ERROR: unexpected coefficient %h last %b", c, l);
      end else begin
         b = coef_q.pop_front();
         if (b.coef !== c || b.last !== l) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: coefficient exp %h last %b, got %h last %b",
                        b.coef, b.last, c, l);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         coef_q.delete();
         fill_count   = 0;
         inverse_mode = 1'b0;
         len_log2     = d4w_pkg::LEN_LOG2_RESET;
         failures     = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == d4w_pkg::CSR_IDX_DIRECTION) inverse_mode = csr_pwdata[0];
            else len_log2 = csr_pwdata[2:0];
         end
         if (rsp_valid && !rsp_stall) check_beat(rsp_coefficient, rsp_last_out);
         if (req_valid && !req_stall) take_sample(req_sample);
      end
      coef_pending = coef_q.size();
   end

endmodule

### verif/tb_daubechies4_wavelet_multilevel.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_daubechies4_wavelet_multilevel
// Drives sample blocks through the D4 wavelet block in both directions and at
// every length setting, with random gaps and back pressure; a checker beside
// the block predicts and compares every coefficient.
// ----------------------------------------------------------------------------
module tb_daubechies4_wavelet_multilevel;

   localparam int LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_coefficient;
   logic        rsp_last_out;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int coef_pending;
   int cycles = 0;
   int sent = 0;
   bit hold_go = 1'b0;
   int hold_left = 0;

   always #10 clock = ~clock;

   daubechies4_wavelet_multilevel DUT (.*);

   daubechies4_wavelet_multilevel_checker u_checker (.*);

   function automatic bit noisy();
      return !(sent >= 250 && sent < 330);
   endfunction

   always @(negedge clock) begin
      if (hold_go && hold_left == 0) begin
         hold_left = 2500;
         hold_go   = 1'b0;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) || (noisy() && $urandom_range(0, 99) < 27);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic csr_write(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_psel   = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr  = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic send_beat(logic [31:0] s);
      @(negedge clock);
      while (noisy() && $urandom_range(0, 99) < 27) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = s;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (coef_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3, 4: return $urandom;
         default: return $urandom_range(0, 8191) - 4096;
      endcase
   endfunction

   function automatic logic [2:0] pick_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return 3'($urandom_range(2, 3));
      if (r < 15) return 3'd4;
      if (r < 17) return 3'd5;
      if (r == 17) return 3'd6;
      if (r == 18) return 3'($urandom_range(0, 1));
      return 3'd7;
   endfunction

   initial begin
      logic [2:0] k;
      int         n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // pass-through at length four, extremes of the sample
      csr_write(d4w_pkg::CSR_IDX_LENGTH, 32'd1);
      send_beat(32'h8000_0000);
      send_beat(32'h7fff_ffff);
      send_beat(32'h0000_0000);
      send_beat(32'hffff_ffff);
      settle();
      csr_write(d4w_pkg::CSR_IDX_LENGTH, 32'd2);
      for (int i = 0; i < 4; i++) send_beat(32'h5555_5555 ^ {32{i[0]}});
      settle();

      // saturation in both directions at length eight
      csr_write(d4w_pkg::CSR_IDX_LENGTH, 32'd3);
      for (int i = 0; i < 8; i++) send_beat(i[0] ? 32'h8000_0000 : 32'h7fff_ffff);
      settle();
      csr_write(d4w_pkg::CSR_IDX_DIRECTION, 32'd1);
      for (int i = 0; i < 8; i++) send_beat(i < 4 ? 32'h7fff_ffff : 32'h8000_0000);
      settle();

      // shrink the length while a block is half loaded
      csr_write(d4w_pkg::CSR_IDX_DIRECTION, 32'd0);
      for (int i = 0; i < 5; i++) send_beat(pick_sample());
      settle();
      csr_write(d4w_pkg::CSR_IDX_LENGTH, 32'd2);
      send_beat(pick_sample());
      settle();

      for (int phase = 0; sent < 410; phase++) begin
         k = (phase == 6) ? 3'd6 : pick_len();
         csr_write(d4w_pkg::CSR_IDX_DIRECTION, {31'd0, 1'($urandom_range(0, 1))});
         csr_write(d4w_pkg::CSR_IDX_LENGTH, {29'd0, k});
         n = (k < 2) ? 4 : (k > 6) ? 64 : (1 << k);
         if (phase == 6) begin
            hold_go = 1'b1;
            n = 2 * n;
         end
         for (int i = 0; i < n; i++) send_beat(pick_sample());
         settle();
      end

      repeat (100) @(posedge clock);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
design/d4w_pkg.sv
design/d4w_ram.sv
design/d4w_datapath.sv
design/d4w_ctrl.sv
design/daubechies4_wavelet_multilevel.sv
design/d4w_checker.sv
verif/daubechies4_wavelet_multilevel_checker.sv
verif/tb_daubechies4_wavelet_multilevel.sv
